// ----- hw/rtl/ps2_scancode_to_ascii_fifo_defines.svh -----
// Assertion macros for the keyboard decoder RTL, used by ps2s2a_fifo.
// Each macro expects aclk and aresetn to be visible in the using module.
`ifndef PS2_SCANCODE_TO_ASCII_FIFO_DEFINES_SVH
`define PS2_SCANCODE_TO_ASCII_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PS2S_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define PS2S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ps2s2a_pkg.sv -----
// Package for the PS/2 set 1 keyboard decoder: constants, types, key tables.
// No dependencies; used by every module of the block but ps2s2a_ram.
`default_nettype none

package ps2s2a_pkg;

    // Character FIFO geometry (holds FIFO_DEPTH-1 characters)
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CHAR_W     = 7;
    localparam int MAP_SIZE   = 58;

    // Word kinds on the input tuser
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Scancode set 1 key codes
    localparam logic [7:0] CODE_LSHIFT = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT = 8'h36;
    localparam logic [7:0] CODE_CTRL   = 8'h1D;
    localparam logic [7:0] CODE_ALT    = 8'h38;
    localparam logic [7:0] CODE_CAPS   = 8'h3A;
    localparam logic [7:0] RELEASE_BIT = 8'h80;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CHAR_W-1:0] char_t;

    // Modifier state
    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } flags_t;

    // Character push request from the decoder to the FIFO
    typedef struct packed {
        logic  push;
        char_t ch;
    } push_req_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    // Unshifted US layout
    function automatic char_t plain_char(input logic [5:0] code);
        case (code)
            6'd1:  plain_char = 7'h1B;
            6'd2:  plain_char = 7'h31;
            6'd3:  plain_char = 7'h32;
            6'd4:  plain_char = 7'h33;
            6'd5:  plain_char = 7'h34;
            6'd6:  plain_char = 7'h35;
            6'd7:  plain_char = 7'h36;
            6'd8:  plain_char = 7'h37;
            6'd9:  plain_char = 7'h38;
            6'd10: plain_char = 7'h39;
            6'd11: plain_char = 7'h30;
            6'd12: plain_char = 7'h2D;
            6'd13: plain_char = 7'h3D;
            6'd14: plain_char = 7'h08;
            6'd15: plain_char = 7'h09;
            6'd16: plain_char = 7'h71;
            6'd17: plain_char = 7'h77;
            6'd18: plain_char = 7'h65;
            6'd19: plain_char = 7'h72;
            6'd20: plain_char = 7'h74;
            6'd21: plain_char = 7'h79;
            6'd22: plain_char = 7'h75;
            6'd23: plain_char = 7'h69;
            6'd24: plain_char = 7'h6F;
            6'd25: plain_char = 7'h70;
            6'd26: plain_char = 7'h5B;
            6'd27: plain_char = 7'h5D;
            6'd28: plain_char = 7'h0A;
            6'd30: plain_char = 7'h61;
            6'd31: plain_char = 7'h73;
            6'd32: plain_char = 7'h64;
            6'd33: plain_char = 7'h66;
            6'd34: plain_char = 7'h67;
            6'd35: plain_char = 7'h68;
            6'd36: plain_char = 7'h6A;
            6'd37: plain_char = 7'h6B;
            6'd38: plain_char = 7'h6C;
            6'd39: plain_char = 7'h3B;
            6'd40: plain_char = 7'h27;
            6'd41: plain_char = 7'h60;
            6'd43: plain_char = 7'h5C;
            6'd44: plain_char = 7'h7A;
            6'd45: plain_char = 7'h78;
            6'd46: plain_char = 7'h63;
            6'd47: plain_char = 7'h76;
            6'd48: plain_char = 7'h62;
            6'd49: plain_char = 7'h6E;
            6'd50: plain_char = 7'h6D;
            6'd51: plain_char = 7'h2C;
            6'd52: plain_char = 7'h2E;
            6'd53: plain_char = 7'h2F;
            6'd55: plain_char = 7'h2A;
            6'd57: plain_char = 7'h20;
            default: plain_char = 7'h00;
        endcase
    endfunction

    // Shifted US layout
    function automatic char_t shift_char(input logic [5:0] code);
        case (code)
            6'd1:  shift_char = 7'h1B;
            6'd2:  shift_char = 7'h21;
            6'd3:  shift_char = 7'h40;
            6'd4:  shift_char = 7'h23;
            6'd5:  shift_char = 7'h24;
            6'd6:  shift_char = 7'h25;
            6'd7:  shift_char = 7'h5E;
            6'd8:  shift_char = 7'h26;
            6'd9:  shift_char = 7'h2A;
            6'd10: shift_char = 7'h28;
            6'd11: shift_char = 7'h29;
            6'd12: shift_char = 7'h5F;
            6'd13: shift_char = 7'h2B;
            6'd14: shift_char = 7'h08;
            6'd15: shift_char = 7'h09;
            6'd16: shift_char = 7'h51;
            6'd17: shift_char = 7'h57;
            6'd18: shift_char = 7'h45;
            6'd19: shift_char = 7'h52;
            6'd20: shift_char = 7'h54;
            6'd21: shift_char = 7'h59;
            6'd22: shift_char = 7'h55;
            6'd23: shift_char = 7'h49;
            6'd24: shift_char = 7'h4F;
            6'd25: shift_char = 7'h50;
            6'd26: shift_char = 7'h7B;
            6'd27: shift_char = 7'h7D;
            6'd28: shift_char = 7'h0A;
            6'd30: shift_char = 7'h41;
            6'd31: shift_char = 7'h53;
            6'd32: shift_char = 7'h44;
            6'd33: shift_char = 7'h46;
            6'd34: shift_char = 7'h47;
            6'd35: shift_char = 7'h48;
            6'd36: shift_char = 7'h4A;
            6'd37: shift_char = 7'h4B;
            6'd38: shift_char = 7'h4C;
            6'd39: shift_char = 7'h3A;
            6'd40: shift_char = 7'h22;
            6'd41: shift_char = 7'h7E;
            6'd43: shift_char = 7'h7C;
            6'd44: shift_char = 7'h5A;
            6'd45: shift_char = 7'h58;
            6'd46: shift_char = 7'h43;
            6'd47: shift_char = 7'h56;
            6'd48: shift_char = 7'h42;
            6'd49: shift_char = 7'h4E;
            6'd50: shift_char = 7'h4D;
            6'd51: shift_char = 7'h3C;
            6'd52: shift_char = 7'h3E;
            6'd53: shift_char = 7'h3F;
            6'd55: shift_char = 7'h2A;
            6'd57: shift_char = 7'h20;
            default: shift_char = 7'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ps2s2a_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ps2s2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ps2s2a_decode.sv -----
// Scancode decoder: modifier flags, caps lock and key-to-ASCII mapping.
// Depends on ps2s2a_pkg.
`default_nettype none

module ps2s2a_decode (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  scan_en,     // accepted scancode word
    input  wire logic [7:0]            scan_byte,
    output ps2s2a_pkg::flags_t         flags_next,  // flags after this word
    output ps2s2a_pkg::push_req_t      push_req
);

    ps2s2a_pkg::flags_t flags_reg;
    ps2s2a_pkg::char_t  mapped;
    logic [7:0]         rel_code;
    logic               is_release;
    logic               is_mod;
    logic               in_map;

    assign is_release = (scan_byte & ps2s2a_pkg::RELEASE_BIT) != 8'h00;
    assign rel_code   = scan_byte & ~ps2s2a_pkg::RELEASE_BIT;
    assign in_map     = scan_byte < 8'(ps2s2a_pkg::MAP_SIZE);
    assign is_mod     = (scan_byte == ps2s2a_pkg::CODE_LSHIFT) ||
                        (scan_byte == ps2s2a_pkg::CODE_RSHIFT) ||
                        (scan_byte == ps2s2a_pkg::CODE_CTRL)   ||
                        (scan_byte == ps2s2a_pkg::CODE_ALT)    ||
                        (scan_byte == ps2s2a_pkg::CODE_CAPS);

    // Table lookup, then caps lock swaps letter case
    always_comb begin
        mapped = flags_reg.shift ? ps2s2a_pkg::shift_char(scan_byte[5:0])
                                 : ps2s2a_pkg::plain_char(scan_byte[5:0]);
        if (flags_reg.caps &&
            (((mapped >= 7'h61) && (mapped <= 7'h7A)) ||
             ((mapped >= 7'h41) && (mapped <= 7'h5A)))) begin
            mapped = mapped ^ 7'h20;
        end
    end

    // Flag update for the current word
    always_comb begin
        flags_next = flags_reg;
        if (scan_en) begin
            if (is_release) begin
                if ((rel_code == ps2s2a_pkg::CODE_LSHIFT) ||
                    (rel_code == ps2s2a_pkg::CODE_RSHIFT)) begin
                    flags_next.shift = 1'b0;
                end else if (rel_code == ps2s2a_pkg::CODE_CTRL) begin
                    flags_next.ctrl = 1'b0;
                end else if (rel_code == ps2s2a_pkg::CODE_ALT) begin
                    flags_next.alt = 1'b0;
                end
            end else begin
                if ((scan_byte == ps2s2a_pkg::CODE_LSHIFT) ||
                    (scan_byte == ps2s2a_pkg::CODE_RSHIFT)) begin
                    flags_next.shift = 1'b1;
                end else if (scan_byte == ps2s2a_pkg::CODE_CTRL) begin
                    flags_next.ctrl = 1'b1;
                end else if (scan_byte == ps2s2a_pkg::CODE_ALT) begin
                    flags_next.alt = 1'b1;
                end else if (scan_byte == ps2s2a_pkg::CODE_CAPS) begin
                    flags_next.caps = ~flags_reg.caps;
                end
            end
        end
    end

    // Character push: plain press of a mapped, nonzero key
    assign push_req.push = scan_en && !is_release && !is_mod && in_map && (mapped != 7'h00);
    assign push_req.ch   = mapped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ps2s2a_fifo.sv -----
// Ring FIFO of ASCII characters: pointers, full/empty logic and the store RAM.
// Depends on ps2s2a_pkg, ps2s2a_ram and the assertion macro header.
`default_nettype none
`include "ps2_scancode_to_ascii_fifo_defines.svh"

module ps2s2a_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ps2s2a_pkg::push_req_t push_req,
    input  wire logic                  pop_en,        // accepted pop word
    output logic                       pop_ok,        // pop returns a character
    output logic                       has_input_next,
    output ps2s2a_pkg::char_t          rd_data        // valid the cycle after pop_ok
);

    ps2s2a_pkg::ptr_t rd_ptr_reg;
    ps2s2a_pkg::ptr_t rd_ptr_next;
    ps2s2a_pkg::ptr_t wr_ptr_reg;
    ps2s2a_pkg::ptr_t wr_ptr_next;
    logic             empty;
    logic             full;
    logic             wr_en;
    logic             rd_en;

    // One slot is kept free to tell full from empty
    assign empty  = rd_ptr_reg == wr_ptr_reg;
    assign full   = ps2s2a_pkg::ptr_next(wr_ptr_reg) == rd_ptr_reg;
    assign wr_en  = push_req.push && !full;
    assign rd_en  = pop_en && !empty;
    assign pop_ok = rd_en;

    assign wr_ptr_next    = wr_en ? ps2s2a_pkg::ptr_next(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next    = rd_en ? ps2s2a_pkg::ptr_next(rd_ptr_reg) : rd_ptr_reg;
    assign has_input_next = rd_ptr_next != wr_ptr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Character store
    ps2s2a_ram #(
        .WIDTH (ps2s2a_pkg::CHAR_W),
        .DEPTH (ps2s2a_pkg::FIFO_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_req.ch),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    `PS2S_ASSERT_NOW(a_no_overfill, wr_en, ps2s2a_pkg::ptr_next(wr_ptr_reg) != rd_ptr_reg, "fifo write while full")
    `PS2S_ASSERT_NOW(a_no_empty_read, rd_en, !empty && !push_req.push, "fifo read while empty or pushing")
    `PS2S_ASSERT_NEXT(a_nonempty_after_push, wr_en, rd_ptr_reg != wr_ptr_reg, "fifo empty after a push")

endmodule

`default_nettype wire

// ----- hw/rtl/ps2_scancode_to_ascii_fifo.sv -----
// PS/2 set 1 keyboard decoder with character FIFO, top level.
// The result word for an accepted input word appears on m_* in the cycle after acceptance.
// One word per cycle while m_tready is high; the output register refills as it drains.
// The popped character comes from the store RAM's registered read port.
// Reset (aresetn low, synchronous): FIFO empty, all flags clear, no result.
// Depends on ps2s2a_pkg, ps2s2a_decode and ps2s2a_fifo.
`default_nettype none

module ps2_scancode_to_ascii_fifo (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  wire logic        s_tuser,   // [0] op (0 scancode, 1 pop)
    // Result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [6:0] char_out, [7] has_input, [8] shift_held,
                                        // [9] ctrl_held, [10] alt_held, [11] caps_on,
                                        // [15:12] zero
    output logic             m_tuser    // [0] char_valid
);

    logic                      accept;
    logic                      scan_en;
    logic                      pop_en;
    logic                      pop_ok;
    logic                      has_input_next;
    ps2s2a_pkg::flags_t        flags_next;
    ps2s2a_pkg::push_req_t     push_req;
    ps2s2a_pkg::char_t         rd_data;

    logic                      out_valid_reg;
    logic                      char_valid_reg;
    logic                      has_input_reg;
    ps2s2a_pkg::flags_t        flags_out_reg;

    // Handshake: take a word whenever the output register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign scan_en  = accept && (s_tuser == ps2s2a_pkg::OP_SCAN);
    assign pop_en   = accept && (s_tuser == ps2s2a_pkg::OP_POP);

    ps2s2a_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_en    (scan_en),
        .scan_byte  (s_tdata),
        .flags_next (flags_next),
        .push_req   (push_req)
    );

    ps2s2a_fifo u_fifo (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push_req       (push_req),
        .pop_en         (pop_en),
        .pop_ok         (pop_ok),
        .has_input_next (has_input_next),
        .rd_data        (rd_data)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            char_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                out_valid_reg  <= 1'b1;
                char_valid_reg <= pop_ok;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            has_input_reg <= has_input_next;
            flags_out_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = char_valid_reg;
    assign m_tdata  = {4'b0000,
                       flags_out_reg.caps, flags_out_reg.alt,
                       flags_out_reg.ctrl, flags_out_reg.shift,
                       has_input_reg,
                       char_valid_reg ? rd_data : 7'h00};

endmodule

`default_nettype wire

// ----- tb/ps2_scancode_to_ascii_fifo_checker.sv -----
// Checker for the PS/2 set 1 keyboard decoder: watches both stream channels,
// tracks modifier flags and the character queue, and compares every result word.
// Depends on ps2s2a_pkg.
`timescale 1ns / 100ps

module ps2_scancode_to_ascii_fifo_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  wire logic        s_tuser,   // [0] op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [6:0] char_out, [7] has_input, [11:8] flags
    input  wire logic        m_tuser,   // [0] char_valid
    output int unsigned      fail_count,
    output int unsigned      words_pending
);

    typedef struct packed {
        logic               char_valid;
        ps2s2a_pkg::char_t  char_out;
        logic               has_input;
        ps2s2a_pkg::flags_t flags;      // shift, ctrl, alt, caps from the top bit down
    } key_result_t;

    // US layout, indexed by make code
    localparam ps2s2a_pkg::char_t KEYS_PLAIN [ps2s2a_pkg::MAP_SIZE] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam ps2s2a_pkg::char_t KEYS_SHIFTED [ps2s2a_pkg::MAP_SIZE] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // Shadow copy of the decoder state
    ps2s2a_pkg::char_t  char_ring [ps2s2a_pkg::FIFO_DEPTH];
    ps2s2a_pkg::ptr_t   rd_ptr;
    ps2s2a_pkg::ptr_t   wr_ptr;
    ps2s2a_pkg::flags_t kb_flags;
    key_result_t        expected_q [$];

    function automatic ps2s2a_pkg::ptr_t step_ptr(input ps2s2a_pkg::ptr_t p);
        return (int'(p) == ps2s2a_pkg::FIFO_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // Table lookup, then caps lock swaps letter case
    function automatic ps2s2a_pkg::char_t key_to_char(input logic [5:0] idx,
                                                      input ps2s2a_pkg::flags_t f);
        ps2s2a_pkg::char_t c;
        c = f.shift ? KEYS_SHIFTED[idx] : KEYS_PLAIN[idx];
        if (f.caps && c >= 7'h61 && c <= 7'h7A) begin
            c = c - 7'h20;
        end else if (f.caps && c >= 7'h41 && c <= 7'h5A) begin
            c = c + 7'h20;
        end
        return c;
    endfunction

    // Advance the shadow state by one input word and build its result word
    task automatic decode_word(input logic op, input logic [7:0] code,
                               output key_result_t r);
        logic [7:0]        key;
        ps2s2a_pkg::char_t c;
        ps2s2a_pkg::ptr_t  nxt;
        key = code & ~ps2s2a_pkg::RELEASE_BIT;
        r = '0;
        if (op == ps2s2a_pkg::OP_POP) begin
            // pop on empty leaves everything as is
            if (rd_ptr != wr_ptr) begin
                r.char_valid = 1'b1;
                r.char_out   = char_ring[rd_ptr];
                rd_ptr       = step_ptr(rd_ptr);
            end
        end else if ((code & ps2s2a_pkg::RELEASE_BIT) != 8'h00) begin
            // break code: only shift, ctrl and alt react
            if (key == ps2s2a_pkg::CODE_LSHIFT || key == ps2s2a_pkg::CODE_RSHIFT) begin
                kb_flags.shift = 1'b0;
            end else if (key == ps2s2a_pkg::CODE_CTRL) begin
                kb_flags.ctrl = 1'b0;
            end else if (key == ps2s2a_pkg::CODE_ALT) begin
                kb_flags.alt = 1'b0;
            end
        end else begin
            case (code)
                ps2s2a_pkg::CODE_LSHIFT,
                ps2s2a_pkg::CODE_RSHIFT: kb_flags.shift = 1'b1;
                ps2s2a_pkg::CODE_CTRL:   kb_flags.ctrl  = 1'b1;
                ps2s2a_pkg::CODE_ALT:    kb_flags.alt   = 1'b1;
                ps2s2a_pkg::CODE_CAPS:   kb_flags.caps  = ~kb_flags.caps;
                default: begin
                    if (code < ps2s2a_pkg::MAP_SIZE) begin
                        c = key_to_char(code[5:0], kb_flags);
                        nxt = step_ptr(wr_ptr);
                        // zero chars are not queued, a full queue drops the char
                        if (c != '0 && nxt != rd_ptr) begin
                            char_ring[wr_ptr] = c;
                            wr_ptr = nxt;
                        end
                    end
                end
            endcase
        end
        r.has_input = (rd_ptr != wr_ptr);
        r.flags     = kb_flags;
    endtask

    task automatic flag_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    initial begin
        fail_count    = 0;
        words_pending = 0;
    end

    always @(posedge aclk) begin : watch
        key_result_t want;
        key_result_t got;
        key_result_t fresh;
        if (!aresetn) begin
            rd_ptr   = '0;
            wr_ptr   = '0;
            kb_flags = '0;
            expected_q.delete();
        end else begin
            // result side first: a word leaving now was accepted on an earlier edge
            if (m_tvalid && m_tready) begin
                got.char_valid = m_tuser;
                got.char_out   = m_tdata[6:0];
                got.has_input  = m_tdata[7];
                got.flags      = {m_tdata[8], m_tdata[9], m_tdata[10], m_tdata[11]};
                if (expected_q.size() == 0) begin
                    flag_failure($sformatf("unexpected result word tdata=%04h tuser=%0b",
                                           m_tdata, m_tuser));
                end else begin
                    want = expected_q.pop_front();
                    if (got.char_valid !== want.char_valid ||
                        got.char_out !== want.char_out ||
                        got.has_input !== want.has_input ||
                        got.flags !== want.flags ||
                        m_tdata[15:12] !== 4'h0) begin
                        flag_failure($sformatf({"result mismatch: expected valid=%0b ",
                            "char=%02h has_input=%0b shift/ctrl/alt/caps=%04b; got valid=%0b ",
                            "char=%02h has_input=%0b shift/ctrl/alt/caps=%04b pad=%h"},
                            want.char_valid, want.char_out, want.has_input, want.flags,
                            got.char_valid, got.char_out, got.has_input, got.flags,
                            m_tdata[15:12]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_word(s_tuser, s_tdata, fresh);
                expected_q.push_back(fresh);
            end
        end
        words_pending <= expected_q.size();
    end

endmodule

// ----- tb/tb_ps2_scancode_to_ascii_fifo.sv -----
// Testbench top for the PS/2 set 1 keyboard decoder: clock, reset and stimulus.
// Result checking lives in ps2_scancode_to_ascii_fifo_checker; uses ps2s2a_pkg.
`timescale 1ns / 100ps

module tb_ps2_scancode_to_ascii_fifo;

    localparam int RUN_WORDS   = 1600;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic        no_gaps  = 1'b0;   // full rate on both sides while set
    int unsigned words_sent = 0;
    int unsigned fail_count;
    int unsigned words_pending;

    ps2_scancode_to_ascii_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ps2_scancode_to_ascii_fifo_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side backpressure
    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 33);
    end

    // Drive one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_word(input logic op, input logic [7:0] code);
        while (!no_gaps && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic press(input logic [7:0] code);
        send_word(ps2s2a_pkg::OP_SCAN, code);
    endtask

    // byte is don't-care on a pop, so it carries noise
    task automatic pop_char();
        send_word(ps2s2a_pkg::OP_POP, 8'($urandom));
    endtask

    // Make code, usually followed by its break code
    task automatic stroke(input logic [7:0] code);
        press(code);
        if ($urandom_range(0, 3) != 0) begin
            press(code | ps2s2a_pkg::RELEASE_BIT);
        end
    endtask

    function automatic logic [7:0] any_key();
        return 8'($urandom_range(0, ps2s2a_pkg::MAP_SIZE - 1));
    endfunction

    // Well-formed typing with modifiers, interleaved with reads
    task automatic typing_burst();
        logic [7:0] mod;
        repeat ($urandom_range(5, 40)) begin
            case ($urandom_range(0, 9))
                0: begin
                    mod = $urandom_range(0, 1) ? ps2s2a_pkg::CODE_LSHIFT
                                               : ps2s2a_pkg::CODE_RSHIFT;
                    press(mod);
                    repeat ($urandom_range(1, 4)) stroke(any_key());
                    press(mod | ps2s2a_pkg::RELEASE_BIT);
                end
                1: stroke(ps2s2a_pkg::CODE_CAPS);
                2: begin
                    mod = $urandom_range(0, 1) ? ps2s2a_pkg::CODE_CTRL
                                               : ps2s2a_pkg::CODE_ALT;
                    press(mod);
                    stroke(any_key());
                    press(mod | ps2s2a_pkg::RELEASE_BIT);
                end
                3, 4: pop_char();
                default: stroke(any_key());
            endcase
        end
    endtask

    // Fill well past capacity at full rate, then read everything back and beyond
    task automatic flood_queue();
        no_gaps <= 1'b1;
        repeat (270) press(8'($urandom_range(16, 25)));
        repeat (260) pop_char();
        no_gaps <= 1'b0;
    endtask

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL ps2_scancode_to_ascii_fifo");
        $finish;
    end

    initial begin : stimulus
        bit flooded;
        flooded = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty read, case rules, modifiers, codes with no character
        pop_char();
        press(8'h00);                     // maps to nothing
        press(8'h10);                     // q
        press(ps2s2a_pkg::CODE_LSHIFT);
        press(8'h10);                     // Q
        press(ps2s2a_pkg::CODE_LSHIFT | ps2s2a_pkg::RELEASE_BIT);
        press(ps2s2a_pkg::CODE_RSHIFT);
        press(8'h02);                     // !
        press(ps2s2a_pkg::CODE_RSHIFT | ps2s2a_pkg::RELEASE_BIT);
        press(ps2s2a_pkg::CODE_CAPS);
        press(8'h1E);                     // A under caps
        press(ps2s2a_pkg::CODE_LSHIFT);
        press(8'h2C);                     // z: shift and caps cancel
        press(ps2s2a_pkg::CODE_LSHIFT | ps2s2a_pkg::RELEASE_BIT);
        press(8'h02);                     // digit is not case swapped
        press(ps2s2a_pkg::CODE_CAPS | ps2s2a_pkg::RELEASE_BIT);   // break of caps does nothing
        press(ps2s2a_pkg::CODE_CAPS);
        press(ps2s2a_pkg::CODE_CTRL);
        press(ps2s2a_pkg::CODE_ALT);
        press(ps2s2a_pkg::CODE_CTRL | ps2s2a_pkg::RELEASE_BIT);
        press(ps2s2a_pkg::CODE_ALT | ps2s2a_pkg::RELEASE_BIT);
        press(8'h39);                     // space, last table entry
        press(8'h3B);                     // beyond the table
        press(8'hFF);
        pop_char();

        // Random phases
        while (words_sent < RUN_WORDS) begin
            if (!flooded && words_sent > 700) begin
                flood_queue();
                flooded = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: typing_burst();
                    6, 7: repeat ($urandom_range(1, 30)) pop_char();
                    default: begin
                        repeat ($urandom_range(3, 20)) begin
                            send_word(1'($urandom), 8'($urandom));
                        end
                    end
                endcase
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the output register settle
        do @(posedge aclk); while (words_pending != 0);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && words_pending == 0) begin
            $display("PASS ps2_scancode_to_ascii_fifo");
        end else begin
            $display("FAIL ps2_scancode_to_ascii_fifo");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ps2s2a_pkg.sv
hw/rtl/ps2s2a_ram.sv
hw/rtl/ps2s2a_decode.sv
hw/rtl/ps2s2a_fifo.sv
hw/rtl/ps2_scancode_to_ascii_fifo.sv
tb/ps2_scancode_to_ascii_fifo_checker.sv
tb/tb_ps2_scancode_to_ascii_fifo.sv
